@@ src/aes_rnd_pkg.sv @@
// Package: operation codes, transaction structs, S-box tables and GF(2^8) helpers
package aes_rnd_pkg;

	typedef enum logic [2:0] {
		OP_ENC      = 3'd0,
		OP_ENC_LAST = 3'd1,
		OP_DEC      = 3'd2,
		OP_DEC_LAST = 3'd3,
		OP_INV_MIX  = 3'd4,
		OP_KEYGEN   = 3'd5
	} aes_op_t;

	typedef struct packed {
		logic [7:0]  round_const;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic [63:0] block_hi;
		logic [63:0] block_lo;
		logic [2:0]  op;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} aes_out_t;

	localparam logic [7:0] FWD_BOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_BOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// one MixColumns column, forward or inverse
	function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
		logic [7:0] b [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		for (int i = 0; i < 4; i++) begin
			b[i]  = c[8*i +: 8];
			x2[i] = xtime(b[i]);
			x4[i] = xtime(x2[i]);
			x8[i] = xtime(x4[i]);
			m2[i] = x2[i];
			m3[i] = x2[i] ^ b[i];
			m9[i] = x8[i] ^ b[i];
			mb[i] = x8[i] ^ x2[i] ^ b[i];
			md[i] = x8[i] ^ x4[i] ^ b[i];
			me[i] = x8[i] ^ x4[i] ^ x2[i];
		end
		for (int r = 0; r < 4; r++) begin
			if (inv)
				mix_col[8*r +: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
			else
				mix_col[8*r +: 8] = m2[r] ^ m3[(r+1)%4] ^ b[(r+2)%4] ^ b[(r+3)%4];
		end
	endfunction

endpackage

@@ src/aes_round_instruction_unit.sv @@
// Top level: three-stage pipelined AES round instruction unit
// One transaction may start every cycle; busy stays low. The result appears
// with done at the end of the pipeline: stage 1 row shift and S-box lookup,
// stage 2 column mix, stage 3 key XOR and result assembly. The receiver
// cannot stall; each result is shown for exactly one cycle.
module aes_round_instruction_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  aes_rnd_pkg::aes_in_t  in_data,
	output logic                done,
	output aes_rnd_pkg::aes_out_t out_data
);
	import aes_rnd_pkg::*;

	logic [127:0] blk, shf, sub, mix;
	logic [127:0] sb_s1, mix_s2;
	logic [127:0] key_s1, key_s2;
	logic [2:0]   op_s1, op_s2;
	logic [7:0]   rc_s1, rc_s2;
	logic         vld_s1, vld_s2, vld_s3;
	aes_out_t     res_s3, res_d;
	logic         inv;
	logic [31:0]  kw1, kw3;

	assign busy = 1'b0;
	assign blk  = {in_data.block_hi, in_data.block_lo};
	assign inv  = (in_data.op == OP_DEC) || (in_data.op == OP_DEC_LAST);

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv)
					shf[8*(4*c+r) +: 8] = blk[8*(4*((c+4-r)%4)+r) +: 8];
				else
					shf[8*(4*c+r) +: 8] = blk[8*(4*((c+r)%4)+r) +: 8];
			end
		end
		for (int i = 0; i < 16; i++)
			sub[8*i +: 8] = inv ? INV_BOX[shf[8*i +: 8]] : FWD_BOX[shf[8*i +: 8]];
		for (int i = 0; i < 4; i++) begin
			kw1[8*i +: 8] = FWD_BOX[blk[32+8*i +: 8]];
			kw3[8*i +: 8] = FWD_BOX[blk[96+8*i +: 8]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= in_data.op;
		key_s1 <= {in_data.key_hi, in_data.key_lo};
		rc_s1  <= in_data.round_const;
		case (in_data.op)
			OP_INV_MIX: sb_s1 <= blk;
			OP_KEYGEN:  sb_s1 <= {kw3, 32'd0, kw1, 32'd0};
			default:    sb_s1 <= sub;
		endcase
	end

	always_comb begin
		for (int c = 0; c < 4; c++)
			mix[32*c +: 32] = mix_col(sb_s1[32*c +: 32], op_s1 != OP_ENC);
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		key_s2 <= key_s1;
		rc_s2  <= rc_s1;
		if (op_s1 == OP_ENC || op_s1 == OP_DEC || op_s1 == OP_INV_MIX)
			mix_s2 <= mix;
		else
			mix_s2 <= sb_s1;
	end

	always_comb begin
		case (op_s2)
			OP_ENC, OP_ENC_LAST, OP_DEC, OP_DEC_LAST: begin
				res_d.result_lo = mix_s2[63:0] ^ key_s2[63:0];
				res_d.result_hi = mix_s2[127:64] ^ key_s2[127:64];
			end
			OP_INV_MIX: begin
				res_d.result_lo = mix_s2[63:0];
				res_d.result_hi = mix_s2[127:64];
			end
			OP_KEYGEN: begin
				res_d.result_lo = {{mix_s2[39:32], mix_s2[63:40]} ^ {24'd0, rc_s2},
					mix_s2[63:32]};
				res_d.result_hi = {{mix_s2[103:96], mix_s2[127:104]} ^ {24'd0, rc_s2},
					mix_s2[127:96]};
			end
			default: begin
				res_d.result_lo = 64'd0;
				res_d.result_hi = 64'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_s3 <= res_d;
	end

	assign done     = vld_s3;
	assign out_data = res_s3;

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start, 3) && $past(arst_n, 3) |-> done) else $error("result lost");
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |=> vld_s3) else $error("stage valid dropped");
	a_op_carry: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> op_s2 == $past(op_s1)) else $error("op misaligned");

endmodule

@@ sim/testbench.sv @@
// Testbench for the AES round instruction unit: directed and random instructions checked against a local model
`timescale 1ns / 100ps

module testbench;
	import aes_rnd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	aes_in_t  in_data;
	logic     done;
	aes_out_t out_data;

	aes_out_t pending_results [$];
	int       error_count;
	int       idle_cycles;

	aes_round_instruction_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.in_data  (in_data),
		.done     (done),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] k);
		logic [8:0] x;
		logic [7:0] acc;
		x   = {1'b0, a};
		acc = 8'h00;
		for (int i = 0; i < 4; i++) begin
			if (k[i])
				acc ^= x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8])
				x ^= 9'h11b;
		end
		return acc;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		logic [31:0] o;
		for (int i = 0; i < 4; i++)
			o[8*i +: 8] = FWD_BOX[w[8*i +: 8]];
		return o;
	endfunction

	function automatic aes_out_t aes_round(input aes_in_t t);
		logic [7:0]   s [16];
		logic [7:0]   u [16];
		logic [3:0]   kf [4];
		logic [3:0]   ki [4];
		logic [31:0]  a;
		logic [31:0]  b;
		logic [127:0] v;
		logic         inv;
		aes_out_t     r;
		kf = '{4'h2, 4'h3, 4'h1, 4'h1};
		ki = '{4'hE, 4'hB, 4'hD, 4'h9};
		r  = '0;
		if (t.op > OP_KEYGEN)
			return r;
		if (t.op == OP_KEYGEN) begin
			a = sub_word(t.block_lo[63:32]);
			b = sub_word(t.block_hi[63:32]);
			r.result_lo = {({a[7:0], a[31:8]} ^ {24'h0, t.round_const}), a};
			r.result_hi = {({b[7:0], b[31:8]} ^ {24'h0, t.round_const}), b};
			return r;
		end
		v   = {t.block_hi, t.block_lo};
		inv = (t.op >= OP_DEC) && (t.op != OP_INV_MIX);
		for (int i = 0; i < 16; i++)
			s[i] = v[8*i +: 8];
		if (t.op != OP_INV_MIX) begin
			for (int row = 0; row < 4; row++)
				for (int col = 0; col < 4; col++)
					u[col*4 + row] = s[(inv ? ((col + 4 - row) % 4) : ((col + row) % 4))*4 + row];
			for (int i = 0; i < 16; i++)
				s[i] = inv ? INV_BOX[u[i]] : FWD_BOX[u[i]];
		end
		if (t.op == OP_ENC || t.op == OP_DEC || t.op == OP_INV_MIX) begin
			for (int col = 0; col < 4; col++)
				for (int row = 0; row < 4; row++) begin
					u[col*4 + row] = 8'h00;
					for (int i = 0; i < 4; i++)
						u[col*4 + row] ^= gf_mul(s[col*4 + i],
							(t.op == OP_ENC) ? kf[(i + 4 - row) % 4] : ki[(i + 4 - row) % 4]);
				end
			s = u;
		end
		for (int i = 0; i < 16; i++)
			v[8*i +: 8] = s[i];
		r = v;
		if (t.op != OP_INV_MIX) begin
			r.result_lo ^= t.key_lo;
			r.result_hi ^= t.key_hi;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	always @(posedge clk) begin
		aes_out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result %h at %0t", out_data, $time);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.result_lo !== want.result_lo)
					report_mismatch("result_lo", out_data.result_lo, want.result_lo);
				if (out_data.result_hi !== want.result_hi)
					report_mismatch("result_hi", out_data.result_hi, want.result_hi);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] edge_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	task automatic send_instruction(input aes_in_t t, input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(aes_round(t));
	endtask

	task automatic test_extremes();
		aes_in_t t;
		for (int op = 0; op < 8; op++) begin
			for (int k = 0; k < 3; k++) begin
				t.op          = op[2:0];
				t.block_lo    = (k == 0) ? '0 : (k == 1) ? '1 : 64'h0123456789abcdef;
				t.block_hi    = (k == 0) ? '0 : (k == 1) ? '1 : 64'hfedcba9876543210;
				t.key_lo      = (k == 1) ? '0 : '1;
				t.key_hi      = (k == 2) ? 64'h0f0f0f0f0f0f0f0f : '0;
				t.round_const = (k == 1) ? 8'hff : (k == 2) ? 8'h01 : 8'h00;
				send_instruction(t, k == 2);
			end
		end
	endtask

	task automatic test_random(input int count);
		aes_in_t t;
		bit      burst;
		burst = 1'b0;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 49) == 0)
				burst = ~burst;
			t.op          = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			t.block_lo    = ($urandom_range(0, 9) == 0) ? edge_value() : rand64();
			t.block_hi    = ($urandom_range(0, 9) == 0) ? edge_value() : rand64();
			t.key_lo      = rand64();
			t.key_hi      = rand64();
			t.round_const = 8'($urandom());
			send_instruction(t, burst);
		end
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		error_count = 0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		in_data     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		wait_drain();
		test_random(650);
		wait_drain();
		test_random(650);
		wait_drain();
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
